@@ rtl/slf_pkg.sv @@
// Package for the line framer: widths, codes and state types shared by all files.
package slf_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned LEN_OUT_W = 6;
    localparam int unsigned CFG_IDX_W = 1;

    // Default line buffer depth
    localparam int unsigned LINE_MAX_DEF = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMENT = 1'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'd61;
    localparam logic [BYTE_W-1:0] COMMENT_RST = 8'd39;

    // Special bytes
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_SP = 8'd32;
    localparam logic [BYTE_W-1:0] BYTE_TAB = 8'd9;

    // Output word kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOS = 2'd2;

    // Line scanner mode
    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_COLLECT,
        SCAN_COMMENT
    } scan_t;

    // Output sequencer state
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_CHECK,
        SEQ_SUMMARY,
        SEQ_EOS
    } seq_t;

endpackage

@@ rtl/slf_in_if.sv @@
// Input channel: source byte and end-of-source flag with valid/ready.
interface slf_in_if;
    import slf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_source;

    modport source (output valid, output data_byte, output end_of_source, input ready);
    modport sink (input valid, input data_byte, input end_of_source, output ready);
endinterface

@@ rtl/slf_out_if.sv @@
// Output channel: framed character, line end summary or end marker with valid/ready.
interface slf_out_if;
    import slf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    ch;
    logic                 in_value;
    logic [LEN_OUT_W-1:0] key_length;
    logic [LEN_OUT_W-1:0] value_length;
    logic                 truncated;
    logic                 last;

    modport source (output valid, output kind, output ch, output in_value,
                    output key_length, output value_length, output truncated,
                    output last, input ready);
    modport sink (input valid, input kind, input ch, input in_value,
                  input key_length, input value_length, input truncated,
                  input last, output ready);
endinterface

@@ rtl/source_line_framer_key_value_core.sv @@
// Top level of the line framer: scanner, line buffer and output sequencer.
//
//  channel  dir  handshake         payload
//  in_ch    in   valid/ready       data_byte, end_of_source
//  out_ch   out  valid/ready       kind, ch, in_value, key_length, value_length,
//                                  truncated, last
//  cfg      in   cfg_we            cfg_index, cfg_data
//
// A line end reads the trimmed line from the buffer one entry at a time through a single
// registered read port (SEQ_READ, then SEQ_CHECK), then emits the line end word and,
// at end of source, the end marker.
// in_ch.ready is low while the sequencer emits; output stalls hold the sequencer.
// rst_n clears all control state; buffer contents are not reset.
module source_line_framer_key_value_core #(
    parameter int unsigned LINE_MAX = slf_pkg::LINE_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    slf_in_if.sink                         in_ch,
    slf_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [slf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slf_pkg::BYTE_W-1:0]     cfg_data
);
    import slf_pkg::*;

    localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
    localparam int unsigned ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // Registers
    logic [BYTE_W-1:0]  sep_reg, sep_next;
    logic [BYTE_W-1:0]  cmt_reg, cmt_next;
    scan_t              scan_reg, scan_next;
    logic               after_cr_reg, after_cr_next;
    logic [LEN_W-1:0]   line_len_reg, line_len_next;
    logic [LEN_W-1:0]   trim_len_reg, trim_len_next;
    logic               ovf_reg, ovf_next;
    seq_t               seq_reg, seq_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic               split_reg, split_next;
    logic [LEN_W-1:0]   kl_reg, kl_next;
    logic [LEN_W-1:0]   vl_reg, vl_next;
    logic               eos_pend_reg, eos_pend_next;
    logic [BYTE_W-1:0]  rdata_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BYTE_W-1:0]    ch_reg, ch_next;
    logic                 inv_reg, inv_next;
    logic [LEN_OUT_W-1:0] klo_reg, klo_next;
    logic [LEN_OUT_W-1:0] vlo_reg, vlo_next;
    logic                 tr_reg, tr_next;
    logic                 last_reg, last_next;

    // Line buffer
    logic [BYTE_W-1:0]  line_mem [LINE_MAX];

    // Control
    logic               in_fire;
    logic               out_free;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0]  d;
    logic               d_blank;
    logic [LEN_W-1:0]   idx_inc;
    logic               idx_done;
    logic               is_sep;

    // Outputs and handshake terms
    always_comb
    begin
        in_ch.ready = (seq_reg == SEQ_IDLE);
        in_fire = in_ch.valid && in_ch.ready;
        out_free = !out_valid_reg || out_ch.ready;
        d = in_ch.data_byte;
        d_blank = (d == BYTE_SP) || (d == BYTE_TAB);
        idx_inc = idx_reg + LEN_ONE;
        idx_done = (idx_inc == trim_len_reg);
        is_sep = !split_reg && (rdata_reg == sep_reg);

        mem_we = 1'b0;
        mem_waddr = line_len_reg[ADDR_W-1:0];
        if (in_fire && !in_ch.end_of_source && !(after_cr_reg && d == BYTE_LF))
        begin
            case (scan_reg)
                SCAN_COLLECT:
                begin
                    mem_we = (d != BYTE_CR) && (line_len_reg < LEN_MAX);
                end
                SCAN_COMMENT:
                begin
                    mem_we = 1'b0;
                end
                default:
                begin
                    mem_we = !d_blank && (d != BYTE_CR) && (d != cmt_reg);
                    mem_waddr = '0;
                end
            endcase
        end

        out_ch.valid = out_valid_reg;
        out_ch.kind = kind_reg;
        out_ch.ch = ch_reg;
        out_ch.in_value = inv_reg;
        out_ch.key_length = klo_reg;
        out_ch.value_length = vlo_reg;
        out_ch.truncated = tr_reg;
        out_ch.last = last_reg;
    end

    // Next state: configuration, scanner, sequencer and output register
    always_comb
    begin
        sep_next = sep_reg;
        cmt_next = cmt_reg;
        scan_next = scan_reg;
        after_cr_next = after_cr_reg;
        line_len_next = line_len_reg;
        trim_len_next = trim_len_reg;
        ovf_next = ovf_reg;
        seq_next = seq_reg;
        idx_next = idx_reg;
        split_next = split_reg;
        kl_next = kl_reg;
        vl_next = vl_reg;
        eos_pend_next = eos_pend_reg;

        out_valid_next = out_valid_reg && !out_ch.ready;
        kind_next = kind_reg;
        ch_next = ch_reg;
        inv_next = inv_reg;
        klo_next = klo_reg;
        vlo_next = vlo_reg;
        tr_next = tr_reg;
        last_next = last_reg;

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEPARATOR: sep_next = cfg_data;
                REG_COMMENT:   cmt_next = cfg_data;
                default:       sep_next = sep_reg;
            endcase
        end

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next = '0;
                    split_next = 1'b0;
                    kl_next = '0;
                    vl_next = '0;
                    if (in_ch.end_of_source)
                    begin
                        eos_pend_next = 1'b1;
                        after_cr_next = 1'b0;
                        scan_next = SCAN_START;
                        if (scan_reg == SCAN_COLLECT)
                        begin
                            seq_next = (trim_len_reg != '0) ? SEQ_READ : SEQ_SUMMARY;
                        end
                        else
                        begin
                            seq_next = SEQ_EOS;
                        end
                    end
                    else if (after_cr_reg && d == BYTE_LF)
                    begin
                        // LF right after CR is swallowed
                        after_cr_next = 1'b0;
                    end
                    else
                    begin
                        after_cr_next = 1'b0;
                        case (scan_reg)
                            SCAN_COLLECT:
                            begin
                                if (d == BYTE_CR)
                                begin
                                    eos_pend_next = 1'b0;
                                    scan_next = SCAN_START;
                                    after_cr_next = 1'b1;
                                    seq_next = (trim_len_reg != '0) ? SEQ_READ : SEQ_SUMMARY;
                                end
                                else if (line_len_reg < LEN_MAX)
                                begin
                                    line_len_next = line_len_reg + LEN_ONE;
                                    // trailing blanks do not move the trimmed end
                                    if (!d_blank)
                                    begin
                                        trim_len_next = line_len_reg + LEN_ONE;
                                    end
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            SCAN_COMMENT:
                            begin
                                if (d == BYTE_CR)
                                begin
                                    scan_next = SCAN_START;
                                    after_cr_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                scan_next = SCAN_START;
                                if (d_blank)
                                begin
                                    scan_next = SCAN_START;
                                end
                                else if (d == BYTE_CR)
                                begin
                                    after_cr_next = 1'b1;
                                end
                                else if (d == cmt_reg)
                                begin
                                    scan_next = SCAN_COMMENT;
                                end
                                else
                                begin
                                    line_len_next = LEN_ONE;
                                    trim_len_next = LEN_ONE;
                                    ovf_next = 1'b0;
                                    scan_next = SCAN_COLLECT;
                                end
                            end
                        endcase
                    end
                end
            end

            // Buffer read in flight
            SEQ_READ:
            begin
                seq_next = SEQ_CHECK;
            end

            // Split or emit the byte just read
            SEQ_CHECK:
            begin
                if (is_sep || out_free)
                begin
                    idx_next = idx_inc;
                    seq_next = idx_done ? SEQ_SUMMARY : SEQ_READ;
                    if (is_sep)
                    begin
                        split_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        kind_next = KIND_CHAR;
                        ch_next = rdata_reg;
                        inv_next = split_reg;
                        klo_next = '0;
                        vlo_next = '0;
                        tr_next = 1'b0;
                        last_next = 1'b0;
                        if (split_reg)
                        begin
                            vl_next = vl_reg + LEN_ONE;
                        end
                        else
                        begin
                            kl_next = kl_reg + LEN_ONE;
                        end
                    end
                end
            end

            // Line end word, then clear the line
            SEQ_SUMMARY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_LINE_END;
                    ch_next = '0;
                    inv_next = 1'b0;
                    klo_next = LEN_OUT_W'(kl_reg);
                    vlo_next = LEN_OUT_W'(vl_reg);
                    tr_next = ovf_reg;
                    last_next = !eos_pend_reg;
                    line_len_next = '0;
                    trim_len_next = '0;
                    ovf_next = 1'b0;
                    seq_next = eos_pend_reg ? SEQ_EOS : SEQ_IDLE;
                end
            end

            // End of source word
            SEQ_EOS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_EOS;
                    ch_next = '0;
                    inv_next = 1'b0;
                    klo_next = '0;
                    vlo_next = '0;
                    tr_next = 1'b0;
                    last_next = 1'b1;
                    line_len_next = '0;
                    trim_len_next = '0;
                    ovf_next = 1'b0;
                    eos_pend_next = 1'b0;
                    seq_next = SEQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEPARATOR_RST;
            cmt_reg <= COMMENT_RST;
            scan_reg <= SCAN_START;
            after_cr_reg <= 1'b0;
            line_len_reg <= '0;
            trim_len_reg <= '0;
            ovf_reg <= 1'b0;
            seq_reg <= SEQ_IDLE;
            idx_reg <= '0;
            split_reg <= 1'b0;
            kl_reg <= '0;
            vl_reg <= '0;
            eos_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sep_reg <= sep_next;
            cmt_reg <= cmt_next;
            scan_reg <= scan_next;
            after_cr_reg <= after_cr_next;
            line_len_reg <= line_len_next;
            trim_len_reg <= trim_len_next;
            ovf_reg <= ovf_next;
            seq_reg <= seq_next;
            idx_reg <= idx_next;
            split_reg <= split_next;
            kl_reg <= kl_next;
            vl_reg <= vl_next;
            eos_pend_reg <= eos_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ch_reg <= ch_next;
        inv_reg <= inv_next;
        klo_reg <= klo_next;
        vlo_reg <= vlo_next;
        tr_reg <= tr_next;
        last_reg <= last_next;
    end

    // Line buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= d;
        end
        rdata_reg <= line_mem[idx_reg[ADDR_W-1:0]];
    end

endmodule

@@ dv/source_line_framer_key_value_core_tb.sv @@
// Testbench for the line framer: directed and random source text checked word by word.
module source_line_framer_key_value_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slf_pkg::*;

    localparam int unsigned LINE_MAX_TB = LINE_MAX_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_OFF_CYCLES = 400;

    // One output word as seen on the result channel
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    ch;
        logic                 in_value;
        logic [LEN_OUT_W-1:0] key_length;
        logic [LEN_OUT_W-1:0] value_length;
        logic                 truncated;
        logic                 last;
    } frame_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0] cfg_data;

    slf_in_if in_ch ();
    slf_out_if out_ch ();

    source_line_framer_key_value_core #(
        .LINE_MAX (LINE_MAX_TB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Framer state mirrored by the predictor
    logic [BYTE_W-1:0] sep_reg;
    logic [BYTE_W-1:0] com_reg;
    scan_t line_mode;
    logic after_cr;
    logic [BYTE_W-1:0] line_buf [LINE_MAX_TB];
    int line_len;
    logic line_cut;

    frame_word_t expected_words [$];
    frame_word_t burst [$];

    // Run control and statistics
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int bytes_sent;
    int words_checked;
    int lines_framed;
    int truncated_lines;
    int sources_ended;
    int settings_used;
    int error_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Predictor: queue one output word of the current burst
    function automatic void add_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] c,
                                     logic inv, int kl, int vl, logic tr);
        frame_word_t w;
        w.kind = kind;
        w.ch = c;
        w.in_value = inv;
        w.key_length = LEN_OUT_W'(kl);
        w.value_length = LEN_OUT_W'(vl);
        w.truncated = tr;
        w.last = 1'b0;
        burst.push_back(w);
    endfunction

    // Predictor: trim the buffered line, split it and emit its characters and summary
    function automatic void flush_line();
        int n;
        int kl;
        int vl;
        logic split;
        n = (line_len > LINE_MAX_TB) ? LINE_MAX_TB : line_len;
        kl = 0;
        vl = 0;
        split = 1'b0;
        while (n > 0 && (line_buf[n-1] == BYTE_SP || line_buf[n-1] == BYTE_TAB))
            n--;
        for (int i = 0; i < n; i++)
        begin
            if (!split && line_buf[i] == sep_reg)
                split = 1'b1;
            else
            begin
                add_word(KIND_CHAR, line_buf[i], split, 0, 0, 1'b0);
                if (split)
                    vl++;
                else
                    kl++;
            end
        end
        add_word(KIND_LINE_END, '0, 1'b0, kl, vl, line_cut);
        lines_framed++;
        if (line_cut)
            truncated_lines++;
        line_len = 0;
        line_cut = 1'b0;
    endfunction

    // Predictor: one accepted word in, its output words appended to the expectations
    function automatic void frame_byte(logic [BYTE_W-1:0] d, logic eos);
        burst.delete();
        if (eos)
        begin
            if (line_mode == SCAN_COLLECT)
                flush_line();
            add_word(KIND_EOS, '0, 1'b0, 0, 0, 1'b0);
            sources_ended++;
            line_mode = SCAN_START;
            after_cr = 1'b0;
            line_len = 0;
            line_cut = 1'b0;
        end
        else if (after_cr && d == BYTE_LF)
            after_cr = 1'b0;
        else
        begin
            after_cr = 1'b0;
            case (line_mode)
                SCAN_COLLECT:
                begin
                    if (d == BYTE_CR)
                    begin
                        flush_line();
                        line_mode = SCAN_START;
                        after_cr = 1'b1;
                    end
                    else if (line_len < LINE_MAX_TB)
                    begin
                        line_buf[line_len] = d;
                        line_len++;
                    end
                    else
                        line_cut = 1'b1;
                end
                SCAN_COMMENT:
                begin
                    if (d == BYTE_CR)
                    begin
                        line_mode = SCAN_START;
                        after_cr = 1'b1;
                    end
                end
                default:
                begin
                    line_mode = SCAN_START;
                    if (d == BYTE_SP || d == BYTE_TAB)
                        line_mode = SCAN_START;
                    else if (d == BYTE_CR)
                        after_cr = 1'b1;
                    else if (d == com_reg)
                        line_mode = SCAN_COMMENT;
                    else
                    begin
                        line_len = 1;
                        line_cut = 1'b0;
                        line_buf[0] = d;
                        line_mode = SCAN_COLLECT;
                    end
                end
            endcase
        end
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            expected_words.push_back(burst[i]);
    endfunction

    // Offer one word on the input channel and wait until it is taken
    task automatic offer_byte(input logic [BYTE_W-1:0] d, input logic eos);
        logic lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (!lowered)
                in_ch.valid <= 1'b0;
            lowered = 1'b1;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.end_of_source <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
        frame_byte(d, eos);
        bytes_sent++;
    endtask

    // Lower valid, wait for every expected word, then let the block go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers in back-to-back writes
    task automatic write_regs(input logic [BYTE_W-1:0] sep, input logic [BYTE_W-1:0] com);
        cfg_we <= 1'b1;
        cfg_index <= REG_SEPARATOR;
        cfg_data <= sep;
        @(posedge clk);
        cfg_index <= REG_COMMENT;
        cfg_data <= com;
        @(posedge clk);
        cfg_we <= 1'b0;
        sep_reg = sep;
        com_reg = com;
        settings_used++;
    endtask

    function automatic logic [BYTE_W-1:0] blank_byte();
        return $urandom_range(1) ? BYTE_SP : BYTE_TAB;
    endfunction

    // Line content: mostly printable, with separators, comment marks, blanks and any byte
    function automatic logic [BYTE_W-1:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return sep_reg;
        if (r < 12)
            return com_reg;
        if (r < 22)
            return blank_byte();
        if (r < 34)
            return BYTE_W'($urandom_range(255));
        return BYTE_W'($urandom_range(33, 126));
    endfunction

    // leading blanks, key, optional separator, value, trailing blanks, CR and sometimes LF
    task automatic send_record();
        int n;
        n = $urandom_range(2);
        repeat (n) offer_byte(blank_byte(), 1'b0);
        n = $urandom_range(6);
        repeat (n) offer_byte(text_byte(), 1'b0);
        if ($urandom_range(3) != 0)
            offer_byte(sep_reg, 1'b0);
        n = $urandom_range(8);
        repeat (n) offer_byte(text_byte(), 1'b0);
        n = $urandom_range(2);
        repeat (n) offer_byte(blank_byte(), 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        if ($urandom_range(1))
            offer_byte(BYTE_LF, 1'b0);
    endtask

    // Lines around and beyond the buffer depth
    task automatic send_long_line();
        int n;
        n = $urandom_range(LINE_MAX_TB - 4, LINE_MAX_TB + 13);
        offer_byte(BYTE_W'($urandom_range(33, 126)), 1'b0);
        repeat (n - 1) offer_byte(text_byte(), 1'b0);
        offer_byte(BYTE_CR, 1'b0);
    endtask

    task automatic send_comment_line();
        int n;
        n = $urandom_range(1);
        repeat (n) offer_byte(blank_byte(), 1'b0);
        offer_byte(com_reg, 1'b0);
        n = $urandom_range(5);
        repeat (n) offer_byte(text_byte(), 1'b0);
        offer_byte(BYTE_CR, 1'b0);
    endtask

    task automatic send_blank_line();
        int n;
        n = $urandom_range(3);
        repeat (n) offer_byte(blank_byte(), 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        if ($urandom_range(1))
            offer_byte(BYTE_LF, 1'b0);
    endtask

    // Raw bytes, CR and LF included
    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            r = $urandom_range(9);
            if (r == 0)
                offer_byte(BYTE_LF, 1'b0);
            else if (r == 1)
                offer_byte(BYTE_CR, 1'b0);
            else
                offer_byte(BYTE_W'($urandom_range(255)), 1'b0);
        end
    endtask

    // Random source text until about count more bytes have been taken
    task automatic run_random(input int count);
        int target;
        int r;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_record();
            else if (r < 63)
                send_long_line();
            else if (r < 73)
                send_comment_line();
            else if (r < 81)
                send_blank_line();
            else if (r < 93)
                send_noise();
            else
                offer_byte(BYTE_W'($urandom_range(255)), 1'b1);
        end
    endtask

    // Special cases at the reset register values
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // leading blanks, split at first separator, second one kept, trailing tab trimmed
        offer_byte(BYTE_SP, 1'b0);
        offer_byte(BYTE_TAB, 1'b0);
        offer_byte("k", 1'b0);
        offer_byte(SEPARATOR_RST, 1'b0);
        offer_byte(BYTE_SP, 1'b0);
        offer_byte("v", 1'b0);
        offer_byte(SEPARATOR_RST, 1'b0);
        offer_byte(BYTE_TAB, 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        offer_byte(BYTE_LF, 1'b0);
        // comment line, blank line, swallowed LF
        offer_byte(COMMENT_RST, 1'b0);
        offer_byte("x", 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        offer_byte(BYTE_LF, 1'b0);
        // LF not after CR starts a line; byte extremes; no separator
        offer_byte(BYTE_LF, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        // end of source mid-line, then on an empty source
        offer_byte("a", 1'b0);
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'h00, 1'b1);
        // fresh source after the end
        offer_byte(BYTE_LF, 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        settle();
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_regs(SEPARATOR_RST, COMMENT_RST);
        run_random(80);
        settle();
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 88;
        recv_stall_pct = 0;
        write_regs(8'h00, 8'hFF);
        run_random(80);
        settle();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        recv_stall_pct = 88;
        write_regs(8'hFF, 8'h00);
        run_random(80);
        settle();
    endtask

    // Separator as CR never splits; comment as space never marks; and the swap
    task automatic test_blank_like_regs();
        send_idle_pct = 11;
        recv_stall_pct = 11;
        write_regs(BYTE_CR, BYTE_SP);
        run_random(30);
        settle();
        write_regs(BYTE_SP, BYTE_CR);
        run_random(30);
        settle();
    endtask

    task automatic test_both_idle();
        send_idle_pct = 11;
        recv_stall_pct = 11;
        write_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        run_random(60);
        settle();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 11;
        write_regs(SEPARATOR_RST, BYTE_W'($urandom_range(255)));
        hold_request = HOLD_OFF_CYCLES;
        run_random(80);
        settle();
    endtask

    // Receiver ready, with random stalls and long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every taken output word with the oldest expectation
    initial
    begin
        frame_word_t got;
        frame_word_t want;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind = out_ch.kind;
                got.ch = out_ch.ch;
                got.in_value = out_ch.in_value;
                got.key_length = out_ch.key_length;
                got.value_length = out_ch.value_length;
                got.truncated = out_ch.truncated;
                got.last = out_ch.last;
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word kind=%0d ch=%0d inv=%0d",
                             $time, got.kind, got.ch, got.in_value,
                             " kl=%0d vl=%0d tr=%0d last=%0d",
                             got.key_length, got.value_length, got.truncated, got.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: mismatch kind/ch/inv/kl/vl/tr/last",
                                 $time,
                                 " expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                 want.kind, want.ch, want.in_value, want.key_length,
                                 want.value_length, want.truncated, want.last,
                                 " actual %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                 got.kind, got.ch, got.in_value, got.key_length,
                                 got.value_length, got.truncated, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no word taken on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
                $display("** source_line_framer_key_value_core: FAILED **");
                $finish;
            end
        end
    end

    // Reset, test sequence and verdict
    initial
    begin
        sep_reg = SEPARATOR_RST;
        com_reg = COMMENT_RST;
        line_mode = SCAN_START;
        after_cr = 1'b0;
        line_len = 0;
        line_cut = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        bytes_sent = 0;
        words_checked = 0;
        lines_framed = 0;
        truncated_lines = 0;
        sources_ended = 0;
        settings_used = 0;
        error_count = 0;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SEPARATOR;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.end_of_source <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_blank_like_regs();
        test_both_idle();
        test_backpressure();

        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected words never arrived", $time, expected_words.size());
        end
        $display("Sent %0d source bytes under %0d register settings; checked %0d output words.",
                 bytes_sent, settings_used, words_checked);
        $display("Framed %0d lines (%0d cut at the buffer depth) and %0d ends of source.",
                 lines_framed, truncated_lines, sources_ended);
        if (error_count == 0)
            $display("** source_line_framer_key_value_core: PASSED **");
        else
            $display("** source_line_framer_key_value_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/slf_pkg.sv
rtl/slf_in_if.sv
rtl/slf_out_if.sv
rtl/source_line_framer_key_value_core.sv
dv/source_line_framer_key_value_core_tb.sv
